// File: sv/smmau_pkg.sv
// smmau_pkg: shared constants, codes and structs of the sparse matrix multiply-add unit
// no dependencies; imported by every module of the block but smmau_ram

package smmau_pkg;

    localparam int MAX_DIM    = 8;
    localparam int IDX_W      = $clog2(MAX_DIM);
    localparam int DIM_W      = 4;
    localparam int ADDR_W     = 2 * IDX_W;
    localparam int DEPTH      = MAX_DIM * MAX_DIM;
    localparam int VAL_W      = 32;
    localparam int ACT_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 4;

    // input action codes
    typedef enum logic [ACT_W-1:0] {
        ACT_LOAD_A  = 2'd0,
        ACT_LOAD_B  = 2'd1,
        ACT_COMPUTE = 2'd2,
        ACT_CLEAR   = 2'd3
    } act_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OP_MODE = 3'd0,
        REG_ROWS_A  = 3'd1,
        REG_COLS_A  = 3'd2,
        REG_ROWS_B  = 3'd3,
        REG_COLS_B  = 3'd4
    } cfg_reg_t;

    // op_mode values
    localparam logic MODE_MUL = 1'b0;
    localparam logic MODE_ADD = 1'b1;

    // classified work kinds in the queue
    typedef enum logic [1:0] {
        KD_LOAD_A,
        KD_LOAD_B,
        KD_COMPUTE,
        KD_CLEAR
    } kind_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_RUN,
        BK_DRAIN,
        BK_FLUSH,
        BK_ERROR
    } back_state_t;

    // configuration with dimensions already saturated to MAX_DIM
    typedef struct packed {
        logic             op_mode;
        logic [DIM_W-1:0] rows_a;
        logic [DIM_W-1:0] cols_a;
        logic [DIM_W-1:0] rows_b;
        logic [DIM_W-1:0] cols_b;
    } cfg_t;

    typedef struct packed {
        kind_t            kind;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [VAL_W-1:0] value;
    } queue_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [VAL_W-1:0] value;
        logic             last;
        logic             empty_res;
        logic             dim_error;
    } result_t;

endpackage

// File: sv/sparse_matrix_multiply_add_unit.sv
// sparse_matrix_multiply_add_unit: top level of the sparse matrix multiply-add unit
// holds the configuration registers; depends on smmau_pkg, smmau_front, smmau_back
//
// channels
//   input (in_valid/in_ready): a word is an action with a (row, column, value) entry;
//   load A and load B write one entry of an 8x8 store, clear zeroes both stores,
//   compute runs A*B or A+B as op_mode selects
//   output (out_valid/out_ready): a compute yields the nonzero result entries in
//   row-major order, the final one flagged by last; an all-zero result gives one
//   word with empty_res, a dimension mismatch one word with dim_error
//   config (cfg_we/cfg_index/cfg_data): written by the user only while the unit is idle
//   (unenforced); dimensions above eight act as eight, loads outside them are dropped
// timing
//   loads and clears pass the two-word queue at one word per cycle while the back end
//   is idle; a compute leaves the queue, walks each row, column and inner index (no
//   inner index in add mode), then drains the pipeline and flushes; a result entry
//   passes the ram read, product or sum, accumulator, pending and output registers
// reset and stalls
//   stores read as zero through per-entry valid flags, op_mode is multiply and all
//   dimensions eight; a stalled output word stops the walk, the queue fills, in_ready drops

module sparse_matrix_multiply_add_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [smmau_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [smmau_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [smmau_pkg::ACT_W-1:0]     action,
    input  logic [smmau_pkg::IDX_W-1:0]     entry_row,
    input  logic [smmau_pkg::IDX_W-1:0]     entry_col,
    input  logic [smmau_pkg::VAL_W-1:0]     entry_value,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [smmau_pkg::IDX_W-1:0]     out_row,
    output logic [smmau_pkg::IDX_W-1:0]     out_col,
    output logic [smmau_pkg::VAL_W-1:0]     out_value,
    output logic                            last,
    output logic                            empty_res,
    output logic                            dim_error
);
    import smmau_pkg::*;

    localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);

    logic             op_mode_reg;
    logic [DIM_W-1:0] rows_a_reg;
    logic [DIM_W-1:0] cols_a_reg;
    logic [DIM_W-1:0] rows_b_reg;
    logic [DIM_W-1:0] cols_b_reg;

    cfg_t             cfg;
    logic             q_valid;
    logic             q_ready;
    queue_item_t      q_item;
    result_t          res;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_mode_reg <= MODE_MUL;
            rows_a_reg  <= DIM_MAX;
            cols_a_reg  <= DIM_MAX;
            rows_b_reg  <= DIM_MAX;
            cols_b_reg  <= DIM_MAX;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_OP_MODE: op_mode_reg <= cfg_data[0];
                REG_ROWS_A:  rows_a_reg  <= cfg_data;
                REG_COLS_A:  cols_a_reg  <= cfg_data;
                REG_ROWS_B:  rows_b_reg  <= cfg_data;
                REG_COLS_B:  cols_b_reg  <= cfg_data;
                default:
                begin
                    op_mode_reg <= op_mode_reg;
                end
            endcase
        end
    end

    // saturate dimensions to the store size
    always_comb
    begin
        cfg.op_mode = op_mode_reg;
        cfg.rows_a  = (rows_a_reg > DIM_MAX) ? DIM_MAX : rows_a_reg;
        cfg.cols_a  = (cols_a_reg > DIM_MAX) ? DIM_MAX : cols_a_reg;
        cfg.rows_b  = (rows_b_reg > DIM_MAX) ? DIM_MAX : rows_b_reg;
        cfg.cols_b  = (cols_b_reg > DIM_MAX) ? DIM_MAX : cols_b_reg;
    end

    smmau_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .entry_row   (entry_row),
        .entry_col   (entry_col),
        .entry_value (entry_value),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_item      (q_item)
    );

    smmau_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (res)
    );

    assign out_row   = res.row;
    assign out_col   = res.col;
    assign out_value = res.value;
    assign last      = res.last;
    assign empty_res = res.empty_res;
    assign dim_error = res.dim_error;

endmodule

// File: sv/smmau_ram.sv
// smmau_ram: generic single-write, single-read ram with registered read data
// no dependencies

module smmau_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/smmau_front.sv
// smmau_front: accepts input words, drops out-of-range loads, classifies the rest
// into a two-entry queue toward the back end; depends on smmau_pkg

module smmau_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  smmau_pkg::cfg_t            cfg,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [smmau_pkg::ACT_W-1:0] action,
    input  logic [smmau_pkg::IDX_W-1:0] entry_row,
    input  logic [smmau_pkg::IDX_W-1:0] entry_col,
    input  logic [smmau_pkg::VAL_W-1:0] entry_value,
    output logic                       q_valid,
    input  logic                       q_ready,
    output smmau_pkg::queue_item_t     q_item
);
    import smmau_pkg::*;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    queue_item_t       slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wptr_reg;
    logic [QPTR_W-1:0] rptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    queue_item_t       item_new;
    logic              in_bounds_a;
    logic              in_bounds_b;
    logic              drop;
    logic              push;
    logic              pop;

    assign in_bounds_a = ({1'b0, entry_row} < cfg.rows_a) && ({1'b0, entry_col} < cfg.cols_a);
    assign in_bounds_b = ({1'b0, entry_row} < cfg.rows_b) && ({1'b0, entry_col} < cfg.cols_b);

    always_comb
    begin
        item_new.row   = entry_row;
        item_new.col   = entry_col;
        item_new.value = entry_value;
        item_new.kind  = KD_CLEAR;
        drop           = 1'b0;
        case (action)
            ACT_LOAD_A:
            begin
                item_new.kind = KD_LOAD_A;
                drop          = !in_bounds_a;
            end
            ACT_LOAD_B:
            begin
                item_new.kind = KD_LOAD_B;
                drop          = !in_bounds_b;
            end
            ACT_COMPUTE:
            begin
                item_new.kind = KD_COMPUTE;
            end
            ACT_CLEAR:
            begin
                item_new.kind = KD_CLEAR;
            end
            default:
            begin
                item_new.kind = KD_CLEAR;
            end
        endcase
    end

    assign in_ready = (count_reg != QCNT_W'(QDEPTH));
    assign push     = in_valid && in_ready && !drop;
    assign q_valid  = (count_reg != '0);
    assign pop      = q_valid && q_ready;
    assign q_item   = slot_reg[rptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wptr_reg <= wptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= item_new;
        end
    end

endmodule

// File: sv/smmau_back.sv
// smmau_back: executes queued loads, clears and compute runs; owns both matrix
// stores, the multiply-accumulate pipeline and the output register; depends on
// smmau_pkg and smmau_ram

module smmau_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  smmau_pkg::cfg_t        cfg,
    input  logic                   q_valid,
    output logic                   q_ready,
    input  smmau_pkg::queue_item_t q_item,
    output logic                   out_valid,
    input  logic                   out_ready,
    output smmau_pkg::result_t     out_item
);
    import smmau_pkg::*;

    back_state_t       state_reg;
    back_state_t       state_next;

    logic [IDX_W-1:0]  r_reg;
    logic [IDX_W-1:0]  c_reg;
    logic [IDX_W-1:0]  k_reg;

    logic [DEPTH-1:0]  a_vld_reg;
    logic [DEPTH-1:0]  b_vld_reg;
    logic              a_ok_reg;
    logic              b_ok_reg;

    // pipeline tags: stage 1 is the ram read, stage 2 the product or add-mode sum, stage 3 the accumulated sum
    logic              s1_valid_reg;
    logic              s1_first_reg;
    logic              s1_last_reg;
    logic              s1_final_reg;
    logic [IDX_W-1:0]  s1_row_reg;
    logic [IDX_W-1:0]  s1_col_reg;
    logic              s2_valid_reg;
    logic              s2_first_reg;
    logic              s2_last_reg;
    logic              s2_final_reg;
    logic [IDX_W-1:0]  s2_row_reg;
    logic [IDX_W-1:0]  s2_col_reg;
    logic [VAL_W-1:0]  s2_val_reg;
    logic              s3_done_reg;
    logic              s3_final_reg;
    logic [IDX_W-1:0]  s3_row_reg;
    logic [IDX_W-1:0]  s3_col_reg;
    logic [VAL_W-1:0]  acc_reg;

    // one nonzero entry held back until we know whether it is the last
    logic              pend_valid_reg;
    logic [IDX_W-1:0]  pend_row_reg;
    logic [IDX_W-1:0]  pend_col_reg;
    logic [VAL_W-1:0]  pend_val_reg;

    logic              out_valid_reg;
    logic              out_valid_next;
    result_t           out_item_reg;
    result_t           out_item_next;
    logic              out_load;

    logic              mode_add;
    logic [DIM_W-1:0]  nr;
    logic [DIM_W-1:0]  nc;
    logic [DIM_W-1:0]  kn;
    logic              dim_bad;
    logic              no_work;
    logic              k_end;
    logic              c_end;
    logic              r_end;
    logic              slot_free;
    logic              adv;
    logic              issue;
    logic              take;
    logic              is_compute;

    logic              wr_a;
    logic              wr_b;
    logic              clr;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] a_raddr;
    logic [ADDR_W-1:0] b_raddr;
    logic [VAL_W-1:0]  a_rdata;
    logic [VAL_W-1:0]  b_rdata;
    logic [VAL_W-1:0]  a_op;
    logic [VAL_W-1:0]  b_op;
    logic [VAL_W-1:0]  prod_lo;

    // run geometry
    assign mode_add = (cfg.op_mode == MODE_ADD);
    assign nr       = cfg.rows_a;
    assign nc       = mode_add ? cfg.cols_a : cfg.cols_b;
    assign kn       = mode_add ? DIM_W'(1) : cfg.cols_a;
    assign dim_bad  = mode_add ? ((cfg.rows_a != cfg.rows_b) || (cfg.cols_a != cfg.cols_b))
                               : (cfg.cols_a != cfg.rows_b);
    assign no_work  = (nr == '0) || (nc == '0) || (kn == '0);
    assign k_end    = ({1'b0, k_reg} == kn - DIM_W'(1));
    assign c_end    = ({1'b0, c_reg} == nc - DIM_W'(1));
    assign r_end    = ({1'b0, r_reg} == nr - DIM_W'(1));

    assign slot_free  = !out_valid_reg || out_ready;
    assign adv        = !(s3_done_reg && (acc_reg != '0) && pend_valid_reg && !slot_free);
    assign take       = adv && s3_done_reg && (acc_reg != '0);
    assign is_compute = (q_item.kind == KD_COMPUTE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid && is_compute)
                begin
                    if (dim_bad)
                    begin
                        state_next = BK_ERROR;
                    end
                    else if (no_work)
                    begin
                        state_next = BK_FLUSH;
                    end
                    else
                    begin
                        state_next = BK_RUN;
                    end
                end
            end
            BK_RUN:
            begin
                if (adv && k_end && c_end && r_end)
                begin
                    state_next = BK_DRAIN;
                end
            end
            BK_DRAIN:
            begin
                if (adv && s3_done_reg && s3_final_reg)
                begin
                    state_next = BK_FLUSH;
                end
            end
            BK_FLUSH:
            begin
                if (slot_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_ERROR:
            begin
                if (slot_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        q_ready = 1'b0;
        issue   = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                q_ready = 1'b1;
            end
            BK_RUN:
            begin
                issue = adv;
            end
            default:
            begin
                q_ready = 1'b0;
                issue   = 1'b0;
            end
        endcase
    end

    assign wr_a  = q_ready && q_valid && (q_item.kind == KD_LOAD_A);
    assign wr_b  = q_ready && q_valid && (q_item.kind == KD_LOAD_B);
    assign clr   = q_ready && q_valid && (q_item.kind == KD_CLEAR);
    assign waddr = {q_item.row, q_item.col};

    assign a_raddr = mode_add ? {r_reg, c_reg} : {r_reg, k_reg};
    assign b_raddr = mode_add ? {r_reg, c_reg} : {k_reg, c_reg};

    smmau_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_store_a (
        .clk   (clk),
        .we    (wr_a),
        .waddr (waddr),
        .wdata (q_item.value),
        .re    (adv),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    smmau_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_store_b (
        .clk   (clk),
        .we    (wr_b),
        .waddr (waddr),
        .wdata (q_item.value),
        .re    (adv),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    // entries never written since reset or clear read as zero
    assign a_op    = a_ok_reg ? a_rdata : '0;
    assign b_op    = b_ok_reg ? b_rdata : '0;
    assign prod_lo = a_op * b_op;

    // output register load
    always_comb
    begin
        out_load      = 1'b0;
        out_item_next = out_item_reg;
        if (take && pend_valid_reg)
        begin
            out_load                = 1'b1;
            out_item_next.row       = pend_row_reg;
            out_item_next.col       = pend_col_reg;
            out_item_next.value     = pend_val_reg;
            out_item_next.last      = 1'b0;
            out_item_next.empty_res = 1'b0;
            out_item_next.dim_error = 1'b0;
        end
        else if (state_reg == BK_FLUSH && slot_free)
        begin
            out_load                = 1'b1;
            out_item_next.row       = pend_valid_reg ? pend_row_reg : '0;
            out_item_next.col       = pend_valid_reg ? pend_col_reg : '0;
            out_item_next.value     = pend_valid_reg ? pend_val_reg : '0;
            out_item_next.last      = 1'b1;
            out_item_next.empty_res = !pend_valid_reg;
            out_item_next.dim_error = 1'b0;
        end
        else if (state_reg == BK_ERROR && slot_free)
        begin
            out_load                = 1'b1;
            out_item_next.row       = '0;
            out_item_next.col       = '0;
            out_item_next.value     = '0;
            out_item_next.last      = 1'b1;
            out_item_next.empty_res = 1'b0;
            out_item_next.dim_error = 1'b1;
        end
    end

    assign out_valid_next = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_IDLE;
            r_reg          <= '0;
            c_reg          <= '0;
            k_reg          <= '0;
            a_vld_reg      <= '0;
            b_vld_reg      <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_done_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;

            if (clr)
            begin
                a_vld_reg <= '0;
                b_vld_reg <= '0;
            end
            else
            begin
                if (wr_a)
                begin
                    a_vld_reg[waddr] <= 1'b1;
                end
                if (wr_b)
                begin
                    b_vld_reg[waddr] <= 1'b1;
                end
            end

            // walk counters
            if (state_reg == BK_IDLE)
            begin
                r_reg <= '0;
                c_reg <= '0;
                k_reg <= '0;
            end
            else if (issue)
            begin
                if (k_end)
                begin
                    k_reg <= '0;
                    if (c_end)
                    begin
                        c_reg <= '0;
                        r_reg <= r_reg + IDX_W'(1);
                    end
                    else
                    begin
                        c_reg <= c_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    k_reg <= k_reg + IDX_W'(1);
                end
            end

            if (adv)
            begin
                s1_valid_reg <= issue;
                s2_valid_reg <= s1_valid_reg;
                s3_done_reg  <= s2_valid_reg && s2_last_reg;
            end

            if (state_reg == BK_FLUSH && slot_free)
            begin
                pend_valid_reg <= 1'b0;
            end
            else if (take)
            begin
                pend_valid_reg <= 1'b1;
            end
        end
    end

    // payload of the pipeline, pending entry and output word
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_ok_reg     <= a_vld_reg[a_raddr];
            b_ok_reg     <= b_vld_reg[b_raddr];
            s1_first_reg <= (k_reg == '0);
            s1_last_reg  <= k_end;
            s1_final_reg <= k_end && c_end && r_end;
            s1_row_reg   <= r_reg;
            s1_col_reg   <= c_reg;
            s2_first_reg <= s1_first_reg;
            s2_last_reg  <= s1_last_reg;
            s2_final_reg <= s1_final_reg;
            s2_row_reg   <= s1_row_reg;
            s2_col_reg   <= s1_col_reg;
            s2_val_reg   <= mode_add ? (a_op + b_op) : prod_lo;
            if (s2_valid_reg)
            begin
                acc_reg      <= s2_first_reg ? s2_val_reg : (acc_reg + s2_val_reg);
                s3_final_reg <= s2_final_reg;
                s3_row_reg   <= s2_row_reg;
                s3_col_reg   <= s2_col_reg;
            end
        end
        if (take)
        begin
            pend_row_reg <= s3_row_reg;
            pend_col_reg <= s3_col_reg;
            pend_val_reg <= acc_reg;
        end
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// File: verif/sparse_matrix_multiply_add_unit_tb.sv
`timescale 1ns / 1ps
// sparse_matrix_multiply_add_unit_tb: self-checking bench with a matrix predictor
// and word scoreboard; depends on smmau_pkg and sparse_matrix_multiply_add_unit

module sparse_matrix_multiply_add_unit_tb;

    import smmau_pkg::*;

    localparam int RANDOM_ITEMS  = 75;
    localparam int SETTLE_CYCLES = 20;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int REPORT_MAX    = 10;

    // mirror of both stores and the registers; predicts the result words of every compute
    class smmau_scoreboard;
        logic [VAL_W-1:0] a_store [DEPTH];
        logic [VAL_W-1:0] b_store [DEPTH];
        logic             op_mode;
        logic [DIM_W-1:0] rows_a;
        logic [DIM_W-1:0] cols_a;
        logic [DIM_W-1:0] rows_b;
        logic [DIM_W-1:0] cols_b;
        result_t          expected_q [$];
        int               mismatches;

        function new();
            clear_stores();
            op_mode    = MODE_MUL;
            rows_a     = 4'd8;
            cols_a     = 4'd8;
            rows_b     = 4'd8;
            cols_b     = 4'd8;
            mismatches = 0;
        endfunction

        function void clear_stores();
            for (int i = 0; i < DEPTH; i++)
            begin
                a_store[i] = '0;
                b_store[i] = '0;
            end
        endfunction

        // dimensions above eight act as eight
        function int clip_dim(logic [DIM_W-1:0] d);
            return (d > MAX_DIM) ? MAX_DIM : int'(d);
        endfunction

        function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_OP_MODE: op_mode = data[0];
                REG_ROWS_A:  rows_a  = data;
                REG_COLS_A:  cols_a  = data;
                REG_ROWS_B:  rows_b  = data;
                REG_COLS_B:  cols_b  = data;
                default: ;
            endcase
        endfunction

        function void push_result(int row, int col, logic [VAL_W-1:0] value,
                                  logic is_last, logic is_empty, logic is_err);
            result_t w;
            w.row       = row[IDX_W-1:0];
            w.col       = col[IDX_W-1:0];
            w.value     = value;
            w.last      = is_last;
            w.empty_res = is_empty;
            w.dim_error = is_err;
            expected_q = {expected_q, w};
        endfunction

        // one accepted input word
        function void note_word(act_t act, logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                                logic [VAL_W-1:0] value);
            int ra, ca, rb, cb, nr, nc, found;
            logic [VAL_W-1:0] acc;
            ra = clip_dim(rows_a);
            ca = clip_dim(cols_a);
            rb = clip_dim(rows_b);
            cb = clip_dim(cols_b);
            case (act)
                ACT_LOAD_A:
                begin
                    if (int'(row) < ra && int'(col) < ca)
                        a_store[int'(row) * MAX_DIM + int'(col)] = value;
                end
                ACT_LOAD_B:
                begin
                    if (int'(row) < rb && int'(col) < cb)
                        b_store[int'(row) * MAX_DIM + int'(col)] = value;
                end
                ACT_CLEAR:
                    clear_stores();
                default:
                begin
                    if ((op_mode == MODE_MUL && ca != rb) ||
                        (op_mode == MODE_ADD && (ra != rb || ca != cb)))
                    begin
                        push_result(0, 0, '0, 1'b1, 1'b0, 1'b1);
                        return;
                    end
                    nr    = ra;
                    nc    = (op_mode == MODE_MUL) ? cb : ca;
                    found = 0;
                    for (int r = 0; r < nr; r++)
                    begin
                        for (int c = 0; c < nc; c++)
                        begin
                            acc = '0;
                            if (op_mode == MODE_MUL)
                            begin
                                // 32-bit context keeps only the low word of each product
                                for (int k = 0; k < ca; k++)
                                    acc = acc + a_store[r * MAX_DIM + k] *
                                                b_store[k * MAX_DIM + c];
                            end
                            else
                                acc = a_store[r * MAX_DIM + c] + b_store[r * MAX_DIM + c];
                            if (acc != '0)
                            begin
                                push_result(r, c, acc, 1'b0, 1'b0, 1'b0);
                                found++;
                            end
                        end
                    end
                    if (found == 0)
                        push_result(0, 0, '0, 1'b1, 1'b1, 1'b0);
                    else
                        expected_q[expected_q.size() - 1].last = 1'b1;
                end
            endcase
        endfunction

        // one accepted result word against the oldest prediction
        function void check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0)
            begin
                if (mismatches < REPORT_MAX)
                    $display({"unexpected result word: row %0d col %0d value %h",
                              " last %b empty %b err %b"},
                             got.row, got.col, got.value, got.last, got.empty_res, got.dim_error);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            if (got.row !== want.row || got.col !== want.col || got.value !== want.value ||
                got.last !== want.last || got.empty_res !== want.empty_res ||
                got.dim_error !== want.dim_error)
            begin
                if (mismatches < REPORT_MAX)
                begin
                    $display({"result mismatch: expected row %0d col %0d value %h",
                              " last %b empty %b err %b"},
                             want.row, want.col, want.value, want.last, want.empty_res,
                             want.dim_error);
                    $display({"                 actual   row %0d col %0d value %h",
                              " last %b empty %b err %b"},
                             got.row, got.col, got.value, got.last, got.empty_res, got.dim_error);
                end
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [ACT_W-1:0]      action;
    logic [IDX_W-1:0]      entry_row;
    logic [IDX_W-1:0]      entry_col;
    logic [VAL_W-1:0]      entry_value;
    logic                  out_valid;
    logic                  out_ready;
    logic [IDX_W-1:0]      out_row;
    logic [IDX_W-1:0]      out_col;
    logic [VAL_W-1:0]      out_value;
    logic                  last;
    logic                  empty_res;
    logic                  dim_error;

    smmau_scoreboard sb = new();
    bit              steady_flow = 1'b0;   // when set neither side idles
    int              cycle_count = 0;

    sparse_matrix_multiply_add_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .entry_row   (entry_row),
        .entry_col   (entry_col),
        .entry_value (entry_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_row     (out_row),
        .out_col     (out_col),
        .out_value   (out_value),
        .last        (last),
        .empty_res   (empty_res),
        .dim_error   (dim_error)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run guard: a hang anywhere ends the run as a failure
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // idle cycles before the next word on either side
    function automatic int draw_gap();
        return steady_flow ? 0 : $urandom_range(0, 10);
    endfunction

    // dimension setting: mostly small, sometimes zero, eight or above eight
    function automatic logic [DIM_W-1:0] pick_dim();
        case ($urandom_range(0, 9))
            0:       return 4'd0;
            1:       return 4'($urandom_range(9, 15));
            2:       return 4'd8;
            default: return 4'($urandom_range(1, 4));
        endcase
    endfunction

    // entry value: small signed values give cancellations and zeros, the rest spans all bits
    function automatic logic [VAL_W-1:0] pick_value();
        logic [VAL_W-1:0] v;
        case ($urandom_range(0, 5))
            0, 1, 2:
            begin
                v = $urandom_range(0, 6);
                v = v - 32'd3;
            end
            3:
            begin
                case ($urandom_range(0, 3))
                    0:       v = 32'h8000_0000;
                    1:       v = 32'h7FFF_FFFF;
                    2:       v = 32'hFFFF_FFFF;
                    default: v = 32'h0000_0001;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // one input word; valid stays up across back-to-back words
    task automatic send_word(input act_t act, input logic [IDX_W-1:0] row,
                             input logic [IDX_W-1:0] col, input logic [VAL_W-1:0] value);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        action      <= act;
        entry_row   <= row;
        entry_col   <= col;
        entry_value <= value;
        do @(posedge clk); while (!in_ready);
        sb.note_word(act, row, col, value);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    // only called while the unit is idle
    task automatic apply_config(input logic mode, input logic [DIM_W-1:0] ra,
                                input logic [DIM_W-1:0] ca, input logic [DIM_W-1:0] rb,
                                input logic [DIM_W-1:0] cb);
        write_reg(REG_OP_MODE, {3'b000, mode});
        write_reg(REG_ROWS_A, ra);
        write_reg(REG_COLS_A, ca);
        write_reg(REG_ROWS_B, rb);
        write_reg(REG_COLS_B, cb);
        cfg_we <= 1'b0;
    endtask

    // drop valid, wait for every predicted word, then let the queue and flush drain
    task automatic finish_phase();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // result side: random stalls on out_ready, one draw per word
    initial
    begin : result_ready
        int stall;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = draw_gap();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // every accepted result word goes to the scoreboard
    always @(posedge clk)
    begin : result_capture
        result_t seen;
        if (rst_n && out_valid && out_ready)
        begin
            seen.row       = out_row;
            seen.col       = out_col;
            seen.value     = out_value;
            seen.last      = last;
            seen.empty_res = empty_res;
            seen.dim_error = dim_error;
            sb.check_result(seen);
        end
    end

    initial
    begin : stimulus
        int               rand_items;
        int               lim_r;
        int               lim_c;
        logic             mode;
        logic [DIM_W-1:0] ra, ca, rb, cb;
        act_t             act;

        rst_n       <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_index   <= REG_OP_MODE;
        cfg_data    <= '0;
        in_valid    <= 1'b0;
        action      <= ACT_LOAD_A;
        entry_row   <= '0;
        entry_col   <= '0;
        entry_value <= '0;
        rand_items  = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: 8x8 multiply on cleared stores is empty
        send_word(ACT_COMPUTE, 3'd0, 3'd0, 32'h0);
        // extreme values and corner entries; 0x80000000 * 2 wraps to zero
        send_word(ACT_LOAD_A, 3'd0, 3'd0, 32'h0000_0001);
        send_word(ACT_LOAD_B, 3'd0, 3'd0, 32'h7FFF_FFFF);
        send_word(ACT_LOAD_A, 3'd7, 3'd7, 32'hFFFF_FFFF);
        send_word(ACT_LOAD_B, 3'd7, 3'd7, 32'h8000_0000);
        send_word(ACT_LOAD_A, 3'd0, 3'd7, 32'h8000_0000);
        send_word(ACT_LOAD_B, 3'd7, 3'd0, 32'h0000_0002);
        send_word(ACT_COMPUTE, 3'd7, 3'd7, 32'hFFFF_FFFF);
        send_word(ACT_CLEAR, 3'd0, 3'd0, 32'h0);
        send_word(ACT_COMPUTE, 3'd0, 3'd0, 32'h0);
        // these stay hidden while the dimensions are small and return at 8x8
        send_word(ACT_LOAD_A, 3'd6, 3'd6, 32'h0000_0003);
        send_word(ACT_LOAD_B, 3'd6, 3'd6, 32'h0000_0004);
        finish_phase();

        // add on 3x5: cancellation, out-of-range drop, wrap past the top
        apply_config(MODE_ADD, 4'd3, 4'd5, 4'd3, 4'd5);
        send_word(ACT_LOAD_A, 3'd2, 3'd4, 32'h0000_0005);
        send_word(ACT_LOAD_B, 3'd2, 3'd4, 32'hFFFF_FFFB);
        send_word(ACT_LOAD_A, 3'd3, 3'd0, 32'h1234_5678);
        send_word(ACT_LOAD_A, 3'd0, 3'd0, 32'h7FFF_FFFF);
        send_word(ACT_LOAD_B, 3'd0, 3'd0, 32'h0000_0001);
        send_word(ACT_COMPUTE, 3'd0, 3'd0, 32'h0);
        finish_phase();

        // dimension mismatch in add mode, then in multiply mode
        apply_config(MODE_ADD, 4'd3, 4'd5, 4'd4, 4'd5);
        send_word(ACT_COMPUTE, 3'd0, 3'd0, 32'h0);
        finish_phase();
        apply_config(MODE_MUL, 4'd3, 4'd5, 4'd4, 4'd5);
        send_word(ACT_COMPUTE, 3'd0, 3'd0, 32'h0);
        finish_phase();

        // zero rows: loads dropped, result empty
        apply_config(MODE_MUL, 4'd0, 4'd2, 4'd2, 4'd3);
        send_word(ACT_LOAD_A, 3'd0, 3'd0, 32'h0000_0009);
        send_word(ACT_COMPUTE, 3'd0, 3'd0, 32'h0);
        finish_phase();

        // settings above eight saturate to an 8x8 multiply
        apply_config(MODE_MUL, 4'd15, 4'd9, 4'd8, 4'd12);
        send_word(ACT_LOAD_A, 3'd7, 3'd6, 32'h7FFF_FFFF);
        send_word(ACT_COMPUTE, 3'd0, 3'd0, 32'h0);
        finish_phase();

        // random phases: mostly fitting dimensions with loads then a compute
        while (rand_items < RANDOM_ITEMS)
        begin
            mode = $urandom_range(0, 1);
            ra   = pick_dim();
            ca   = pick_dim();
            rb   = pick_dim();
            cb   = pick_dim();
            if ($urandom_range(0, 3) != 0)
            begin
                if (mode == MODE_MUL)
                    rb = ca;
                else
                begin
                    rb = ra;
                    cb = ca;
                end
            end
            steady_flow = ($urandom_range(0, 3) == 0);
            apply_config(mode, ra, ca, rb, cb);
            repeat ($urandom_range(1, 3))
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    send_word(ACT_CLEAR, 3'($urandom), 3'($urandom), $urandom);
                    rand_items++;
                end
                // noise: any action with any fields
                if ($urandom_range(0, 9) == 0)
                begin
                    act = act_t'($urandom_range(0, 3));
                    send_word(act, 3'($urandom), 3'($urandom), pick_value());
                    rand_items++;
                end
                repeat ($urandom_range(2, 8))
                begin
                    act = ($urandom_range(0, 1) == 0) ? ACT_LOAD_A : ACT_LOAD_B;
                    if (act == ACT_LOAD_A)
                    begin
                        lim_r = sb.clip_dim(sb.rows_a);
                        lim_c = sb.clip_dim(sb.cols_a);
                    end
                    else
                    begin
                        lim_r = sb.clip_dim(sb.rows_b);
                        lim_c = sb.clip_dim(sb.cols_b);
                    end
                    // mostly inside the matrix, now and then anywhere
                    send_word(act,
                              ($urandom_range(0, 6) != 0 && lim_r > 0) ?
                                  3'($urandom_range(0, lim_r - 1)) : 3'($urandom_range(0, 7)),
                              ($urandom_range(0, 6) != 0 && lim_c > 0) ?
                                  3'($urandom_range(0, lim_c - 1)) : 3'($urandom_range(0, 7)),
                              pick_value());
                    rand_items++;
                end
                send_word(ACT_COMPUTE, 3'($urandom), 3'($urandom), $urandom);
                rand_items++;
            end
            finish_phase();
        end

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: sparse_matrix_multiply_add_unit.f
sv/smmau_pkg.sv
sv/smmau_ram.sv
sv/smmau_front.sv
sv/smmau_back.sv
sv/sparse_matrix_multiply_add_unit.sv
verif/sparse_matrix_multiply_add_unit_tb.sv
